### rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
  } dp_cmd_t;

endpackage

### rtl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Handshake controller: takes one transaction, then holds the result.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t dp_cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    dp_cmd.load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/deq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dp
// Ring store, front pointer, occupancy count and result registers.
// ----------------------------------------------------------------------------
module deq_dp
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  dp_cmd,
  input  logic [1:0]               in_command,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [1:0]               out_status
);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [DATA_W-1:0] rd_data_r;
  status_t           status_r, status_nxt;
  logic              is_pop_r;

  logic              empty, full, wr_en, is_pop;
  logic [IDX_W-1:0]  front_inc, front_dec, addr;
  logic [SUM_W-1:0]  tail_sum, tail_wrap, back_sum, back_wrap;

  assign empty = (occ_r == '0);
  assign full  = (occ_r == CNT_W'(DEPTH));

  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;

  assign tail_sum  = SUM_W'(front_r) + SUM_W'(occ_r);
  assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
  assign back_sum  = tail_sum - 1'b1;
  assign back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;

  always_comb begin
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    status_nxt = STAT_DONE;
    wr_en      = 1'b0;
    is_pop     = 1'b0;
    addr       = front_r;
    unique case (in_command)
      CMD_PUSH_FRONT: begin
        addr = front_dec;
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          front_nxt = front_dec;
          occ_nxt   = occ_r + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        addr = tail_wrap[IDX_W-1:0];
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          occ_nxt = occ_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        is_pop = 1'b1;
        addr   = front_r;
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          front_nxt = front_inc;
          occ_nxt   = occ_r - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        is_pop = 1'b1;
        addr   = back_wrap[IDX_W-1:0];
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          occ_nxt = occ_r - 1'b1;
        end
      end
      default: status_nxt = STAT_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      occ_r   <= '0;
    end else if (dp_cmd.load) begin
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load && wr_en) begin
      mem[addr] <= in_push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      rd_data_r <= mem[addr];
      status_r  <= status_nxt;
      is_pop_r  <= is_pop;
    end
  end

  always_comb begin
    if (status_r == STAT_EMPTY) begin
      out_popped_value = '1;
    end else if (is_pop_r) begin
      out_popped_value = rd_data_r;
    end else begin
      out_popped_value = '0;
    end
  end

  assign out_status = status_r;

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_command, in_push_value
//  out_    | output    | out_valid / out_ready | out_popped_value, out_status
//
//  One transaction at a time: each command is accepted, then its result
//  stays in S_RESP until out_ready is high; the ring has a single port.
//  The ring is read and written in the accept cycle; the result is held
//  in registers until taken. in_ready is low while a result is pending.
//  Synchronous active-low reset empties the queue; the ring needs no clear.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic [1:0]               out_status
);

  dp_cmd_t dp_cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  deq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .dp_cmd           (dp_cmd),
    .in_command       (in_command),
    .in_push_value    (in_push_value),
    .out_popped_value (out_popped_value),
    .out_status       (out_status)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted transaction");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_DONE || out_status == STAT_EMPTY ||
                   out_status == STAT_FULL))
    else $error("bad status code");
`endif

endmodule
